@@ design/hsec_pkg.sv @@
// ----------------------------------------------------------------------------
// hsec_pkg
// Types, constants and helper functions for the Hamming SEC encode/correct unit.
// ----------------------------------------------------------------------------
package hsec_pkg;

  localparam int DATA_W = 32;
  localparam int CODE_W = 38;
  localparam int SYN_W  = 6;
  localparam int LEN_W  = 6;
  localparam int CFG_W  = 6;
  localparam int STAT_W = 2;

  localparam logic [CFG_W-1:0] DATA_BITS_RESET = CFG_W'(4);

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FIXED  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BEYOND = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] data_word;
    logic [CODE_W-1:0] received_code;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_out;
    logic [SYN_W-1:0]  syndrome;
    logic [STAT_W-1:0] check_status;
  } rsp_t;

  // codeword built or masked, waiting for its syndrome
  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] word;
  } word_stage_t;

  typedef struct packed {
    logic              req_type;
    logic [CODE_W-1:0] word;
    logic [SYN_W-1:0]  syn;
  } synd_stage_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] mask;
  } code_cfg_t;

  function automatic logic is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // data bit index that lands on codeword bit b (position b+1)
  function automatic int data_idx(input int b);
    int cnt;
    cnt = 0;
    for (int q = 1; q <= b; q++) begin
      if (!is_pow2(q)) cnt++;
    end
    return cnt;
  endfunction

  function automatic logic [LEN_W-1:0] code_len(input logic [CFG_W-1:0] kreg);
    int k;
    int r;
    k = int'(kreg);
    r = 0;
    if (k < 1) k = 1;
    if (k > DATA_W) k = DATA_W;
    for (int i = 0; i < 7; i++) begin
      if ((1 << r) < r + k + 1) r++;
    end
    return LEN_W'(k + r);
  endfunction

  function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    for (int b = 0; b < CODE_W; b++) begin
      m[b] = (LEN_W'(b) < len);
    end
    return m;
  endfunction

endpackage

@@ design/hamming_sec_encode_correct_unit.sv @@
// ----------------------------------------------------------------------------
// hamming_sec_encode_correct_unit
// Even-parity Hamming single-error-correcting encoder and checker with a
// configurable data length.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  request   start / busy              req  (req_type, data_word, received_code)
//  result    done (one-cycle strobe)   rsp  (code_out, syndrome, check_status)
//  config    cfg_valid / cfg_ready     cfg_data (data_bits)
//
//  one item per cycle, each result strobed on done as it leaves the result register
//  stages: input register, codeword layout, syndrome tree, correction/result
//  busy is high during reset and in the cycle after it; no state is kept between items
//  the result side has no back-pressure, so the pipeline never stalls
//  the config port takes writes whenever busy is low
// ----------------------------------------------------------------------------
module hamming_sec_encode_correct_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  hsec_pkg::req_t              req,
  output logic                        done,
  output hsec_pkg::rsp_t              rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hsec_pkg::CFG_W-1:0]  cfg_data
);
  import hsec_pkg::*;

  code_cfg_t   code_cfg;
  logic        accept;
  logic        place_valid;
  word_stage_t place_stage;
  logic        synd_valid;
  synd_stage_t synd_stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  hsec_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_data  (cfg_data),
    .code_cfg (code_cfg)
  );

  hsec_place u_place (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .req       (req),
    .mask      (code_cfg.mask),
    .out_valid (place_valid),
    .out_stage (place_stage)
  );

  hsec_synd u_synd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (place_valid),
    .in_stage  (place_stage),
    .out_valid (synd_valid),
    .out_stage (synd_stage)
  );

  hsec_fix u_fix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (synd_valid),
    .in_stage (synd_stage),
    .code_cfg (code_cfg),
    .done     (done),
    .rsp      (rsp)
  );

  // every accepted item comes out as a done strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("accepted item produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without an accepted item");

  a_len_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.code_out & ~code_cfg.mask) == '0)
    else $error("code_out has bits beyond the code length");

  a_ok_zero_syn: assert property (@(posedge clk) disable iff (rst)
    done && rsp.check_status == STATUS_OK |-> rsp.syndrome == '0)
    else $error("clean status with nonzero syndrome");

  a_fixed_syn: assert property (@(posedge clk) disable iff (rst)
    done && rsp.check_status == STATUS_FIXED |->
      rsp.syndrome != '0 && LEN_W'(rsp.syndrome) <= code_cfg.len)
    else $error("correction with syndrome outside the code");

endmodule

@@ design/hsec_cfg.sv @@
// ----------------------------------------------------------------------------
// hsec_cfg
// Data length register; keeps the code length and its bit mask ready.
// ----------------------------------------------------------------------------
module hsec_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [hsec_pkg::CFG_W-1:0] wr_data,
  output hsec_pkg::code_cfg_t       code_cfg
);
  import hsec_pkg::*;

  code_cfg_t code_cfg_next;

  always_comb begin
    code_cfg_next.len  = code_len(wr_data);
    code_cfg_next.mask = len_mask(code_cfg_next.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_cfg.len  <= code_len(DATA_BITS_RESET);
      code_cfg.mask <= len_mask(code_len(DATA_BITS_RESET));
    end else if (wr_en) begin
      code_cfg <= code_cfg_next;
    end
  end

endmodule

@@ design/hsec_place.sv @@
// ----------------------------------------------------------------------------
// hsec_place
// Input register and codeword layout: data bits spread over the non-parity
// positions, or the received word cut to the code length.
// ----------------------------------------------------------------------------
module hsec_place (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  hsec_pkg::req_t             req,
  input  logic [hsec_pkg::CODE_W-1:0] mask,
  output logic                       out_valid,
  output hsec_pkg::word_stage_t      out_stage
);
  import hsec_pkg::*;

  logic        req_valid;
  req_t        req_q;
  word_stage_t stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      req_valid <= in_valid;
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    req_q     <= req;
    out_stage <= stage_next;
  end

  always_comb begin
    stage_next.req_type = req_q.req_type;
    for (int b = 0; b < CODE_W; b++) begin
      if (req_q.req_type == REQ_CHECK) begin
        stage_next.word[b] = req_q.received_code[b];
      end else if (is_pow2(b + 1) || data_idx(b) >= DATA_W) begin
        stage_next.word[b] = 1'b0;
      end else begin
        stage_next.word[b] = req_q.data_word[data_idx(b) % DATA_W];
      end
    end
    stage_next.word = stage_next.word & mask;
  end

endmodule

@@ design/hsec_synd.sv @@
// ----------------------------------------------------------------------------
// hsec_synd
// Syndrome stage: XOR of the positions of all set bits.
// ----------------------------------------------------------------------------
module hsec_synd (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  hsec_pkg::word_stage_t in_stage,
  output logic                  out_valid,
  output hsec_pkg::synd_stage_t out_stage
);
  import hsec_pkg::*;

  logic [SYN_W-1:0] syn_next;

  // one xor tree per syndrome bit
  always_comb begin
    syn_next = '0;
    for (int b = 0; b < CODE_W; b++) begin
      if (in_stage.word[b]) syn_next = syn_next ^ SYN_W'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage.req_type <= in_stage.req_type;
    out_stage.word     <= in_stage.word;
    out_stage.syn      <= syn_next;
  end

endmodule

@@ design/hsec_fix.sv @@
// ----------------------------------------------------------------------------
// hsec_fix
// Final stage: parity insertion on encode, single-bit flip on check, and the
// result register.
// ----------------------------------------------------------------------------
module hsec_fix (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  hsec_pkg::synd_stage_t in_stage,
  input  hsec_pkg::code_cfg_t   code_cfg,
  output logic                  done,
  output hsec_pkg::rsp_t        rsp
);
  import hsec_pkg::*;

  rsp_t rsp_next;
  logic in_range;

  assign in_range = (LEN_W'(in_stage.syn) <= code_cfg.len);

  always_comb begin
    rsp_next.code_out     = in_stage.word;
    rsp_next.syndrome     = '0;
    rsp_next.check_status = STATUS_OK;
    if (in_stage.req_type == REQ_ENCODE) begin
      for (int j = 0; j < SYN_W; j++) begin
        if ((1 << j) <= CODE_W && in_stage.syn[j]) begin
          rsp_next.code_out[((1 << j) - 1) % CODE_W] = 1'b1;
        end
      end
    end else begin
      rsp_next.syndrome = in_stage.syn;
      if (in_stage.syn != '0) begin
        if (in_range) begin
          rsp_next.check_status = STATUS_FIXED;
          for (int b = 0; b < CODE_W; b++) begin
            if (in_stage.syn == SYN_W'(b + 1)) rsp_next.code_out[b] = ~in_stage.word[b];
          end
        end else begin
          rsp_next.check_status = STATUS_BEYOND;
        end
      end
    end
    rsp_next.code_out = rsp_next.code_out & code_cfg.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule
